FILE: sv/qrse_pkg.sv
// ----------------------------------------------------------------------------
// qrse_pkg
// Shared types, constants and lookup functions of the QR data segment encoder.
// ----------------------------------------------------------------------------
package qrse_pkg;

  // saturation limits
  localparam int unsigned MaxChars = 8191;
  localparam int unsigned CountW   = 13;
  localparam int unsigned BitsW    = 17;
  localparam logic [BitsW-1:0] BitsSat = {BitsW{1'b1}};

  // configuration register indexes
  localparam logic REG_ENCODING_MODE  = 1'b0;
  localparam logic REG_SYMBOL_VERSION = 1'b1;

  // stream widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 48;

  // segment modes
  typedef enum logic [1:0] {
    MODE_NUMERIC = 2'd0,
    MODE_ALNUM   = 2'd1,
    MODE_BYTE    = 2'd2
  } mode_e;

  // one input beat
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } item_t;

  // one result beat
  typedef struct packed {
    logic                    group_valid;
    logic [10:0]             group_value;
    logic [3:0]              group_bits;
    logic                    bad_char;
    logic [CountW-1:0]       char_count;
    logic [BitsW-1:0]        segment_bits;
    logic                    count_overflow;
    logic                    segment_end;
  } result_t;

  // alphanumeric table entry
  typedef struct packed {
    logic       legal;
    logic [5:0] code;
  } alnum_t;

  // 45-symbol alphanumeric set
  function automatic alnum_t alnum_lookup(input logic [7:0] c);
    alnum_t r;
    r.legal = 1'b1;
    r.code  = 6'd0;
    priority if (c >= 8'h30 && c <= 8'h39) begin
      r.code = 6'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r.code = 6'(c - 8'h37);
    end else begin
      unique case (c)
        8'h20:   r.code = 6'd36;
        8'h24:   r.code = 6'd37;
        8'h25:   r.code = 6'd38;
        8'h2A:   r.code = 6'd39;
        8'h2B:   r.code = 6'd40;
        8'h2D:   r.code = 6'd41;
        8'h2E:   r.code = 6'd42;
        8'h2F:   r.code = 6'd43;
        8'h3A:   r.code = 6'd44;
        default: r.legal = 1'b0;
      endcase
    end
    return r;
  endfunction

  // count indicator width by mode and version band
  function automatic logic [4:0] cc_width(input mode_e mode, input logic [5:0] version);
    logic [1:0] band;
    logic [4:0] w;
    if (version <= 6'd9) begin
      band = 2'd0;
    end else if (version <= 6'd26) begin
      band = 2'd1;
    end else begin
      band = 2'd2;
    end
    unique case (mode)
      MODE_NUMERIC: w = (band == 2'd0) ? 5'd10 : ((band == 2'd1) ? 5'd12 : 5'd14);
      MODE_ALNUM:   w = (band == 2'd0) ? 5'd9  : ((band == 2'd1) ? 5'd11 : 5'd13);
      default:      w = (band == 2'd0) ? 5'd8  : 5'd16;
    endcase
    return w;
  endfunction

endpackage

FILE: sv/qr_data_segment_encoder.sv
// ----------------------------------------------------------------------------
// qr_data_segment_encoder
// QR data segment encoder for numeric, alphanumeric and byte modes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character per beat (tdata = char code, tlast marks
//   the final character of a segment). m_axis returns one beat per input
//   beat: the packed bit group (if any), the sticky bad-character flag and,
//   on the tlast beat, character count, total segment bits and overflow.
//   The cfg port writes encoding_mode (index 0) and symbol_version (index 1);
//   write only while no beat is in flight. Writing the mode drops a pending
//   partial group.
//   An accepted beat is held in the input register, then the group packer
//   and segment counters feed the result register that drives m_axis.
//   Throughput is one character per cycle while m_axis does not stall; the
//   packer's multiply-accumulate by 10 or 45 and the running totals are
//   combinational, so consecutive characters of a segment follow each other.
//   Reset clears both stages and the segment state and selects numeric
//   mode, version 1. When m_axis stalls the result is held, one more input
//   beat is buffered, and then s_axis_tready drops.
// ----------------------------------------------------------------------------
module qr_data_segment_encoder
  import qrse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input characters
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] char_code
  input  logic                s_axis_tlast,   // last_char
  // results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] group_valid, [11:1] group_value, [15:12] group_bits, [16] bad_char,
  // [29:17] char_count, [46:30] segment_bits, [47] count_overflow
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,   // segment_end
  // configuration
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [5:0]          cfg_wdata_i
);

  item_t   in_item;
  item_t   cur_item;
  logic    cur_valid;
  logic    advance;
  result_t result;

  assign in_item.char_code = s_axis_tdata;
  assign in_item.last_char = s_axis_tlast;

  // a held character moves on when the result register is free
  assign advance = cur_valid && (!m_axis_tvalid || m_axis_tready);

  qrse_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .advance_i  (advance),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  qrse_encode u_encode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .item_i      (cur_item),
    .result_o    (result)
  );

  qrse_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .result_i    (result),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

FILE: sv/qrse_in_stage.sv
// ----------------------------------------------------------------------------
// qrse_in_stage
// Input register of the encoder; refills in the cycle its beat moves on.
// ----------------------------------------------------------------------------
module qrse_in_stage
  import qrse_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  item_t  in_item_i,
  input  logic   advance_i,
  output logic   valid_o,
  output item_t  item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  // accept when empty or when the held beat leaves this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: sv/qrse_encode.sv
// ----------------------------------------------------------------------------
// qrse_encode
// Configuration registers, segment state and the combinational group packer.
// ----------------------------------------------------------------------------
module qrse_encode
  import qrse_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [5:0]    cfg_wdata_i,
  input  logic          advance_i,
  input  item_t         item_i,
  output result_t       result_o
);

  // configuration
  logic [1:0]        mode_q;
  logic [5:0]        version_q;

  // segment state
  logic [9:0]        acc_q, acc_d;
  logic [1:0]        fill_q, fill_d;
  logic [CountW-1:0] chars_q, chars_d;
  logic [BitsW-1:0]  dbits_q, dbits_d;
  logic              illegal_q, illegal_d;

  mode_e             mode;
  alnum_t            alnum;
  logic              legal;
  logic [5:0]        sym;
  logic [15:0]       acc_mac;
  logic [2:0]        fill_nx;
  logic              flush;
  logic [10:0]       gv;
  logic [3:0]        gb;
  logic [BitsW:0]    dbits_sum;
  logic [BitsW-1:0]  dbits_nx;
  logic [4:0]        ccb;
  logic [BitsW:0]    total_sum;
  logic [BitsW:0]    cc_limit;

  // effective mode, code 3 behaves as byte mode
  always_comb begin
    unique case (mode_q)
      MODE_NUMERIC: mode = MODE_NUMERIC;
      MODE_ALNUM:   mode = MODE_ALNUM;
      default:      mode = MODE_BYTE;
    endcase
  end

  // symbol value and legality
  assign alnum = alnum_lookup(item_i.char_code);
  always_comb begin
    legal = 1'b1;
    sym   = 6'd0;
    unique case (mode)
      MODE_NUMERIC: begin
        legal = (item_i.char_code >= 8'h30) && (item_i.char_code <= 8'h39);
        sym   = legal ? 6'(item_i.char_code - 8'h30) : 6'd0;
      end
      MODE_ALNUM: begin
        legal = alnum.legal;
        sym   = alnum.legal ? alnum.code : 6'd0;
      end
      default: begin
        legal = 1'b1;
        sym   = 6'd0;
      end
    endcase
  end

  // group packing: multiply-accumulate by the radix of the mode
  assign fill_nx = {1'b0, fill_q} + 3'd1;
  always_comb begin
    acc_mac = 16'd0;
    flush   = 1'b0;
    gv      = 11'd0;
    gb      = 4'd0;
    acc_d   = acc_q;
    fill_d  = fill_q;
    unique case (mode)
      MODE_NUMERIC: begin
        acc_mac = 16'(acc_q) * 16'd10 + 16'(sym);
        flush   = (fill_nx >= 3'd3) || item_i.last_char;
        if (flush) begin
          gv     = {1'b0, acc_mac[9:0]};
          gb     = (fill_nx >= 3'd3) ? 4'd10 : 4'((fill_nx * 3'd3) + 3'd1);
          acc_d  = 10'd0;
          fill_d = 2'd0;
        end else begin
          acc_d  = acc_mac[9:0];
          fill_d = fill_nx[1:0];
        end
      end
      MODE_ALNUM: begin
        acc_mac = 16'(acc_q) * 16'd45 + 16'(sym);
        flush   = (fill_nx >= 3'd2) || item_i.last_char;
        if (flush) begin
          gv     = acc_mac[10:0];
          gb     = (fill_nx >= 3'd2) ? 4'd11 : 4'd6;
          acc_d  = 10'd0;
          fill_d = 2'd0;
        end else begin
          acc_d  = acc_mac[9:0];
          fill_d = fill_nx[1:0];
        end
      end
      default: begin
        gv = {3'd0, item_i.char_code};
        gb = 4'd8;
      end
    endcase
  end

  // running totals
  assign chars_d   = (chars_q < CountW'(MaxChars)) ? chars_q + CountW'(1) : chars_q;
  assign illegal_d = illegal_q || !legal;
  assign dbits_sum = {1'b0, dbits_q} + (BitsW+1)'(gb);
  assign dbits_nx  = dbits_sum[BitsW] ? BitsSat : dbits_sum[BitsW-1:0];
  assign dbits_d   = dbits_nx;

  // segment summary
  assign ccb       = cc_width(mode, version_q);
  assign total_sum = (BitsW+1)'(4) + (BitsW+1)'(ccb) + {1'b0, dbits_nx};
  assign cc_limit  = (BitsW+1)'(1) << ccb;

  always_comb begin
    result_o.group_valid    = (gb != 4'd0);
    result_o.group_value    = gv;
    result_o.group_bits     = gb;
    result_o.bad_char       = illegal_d;
    result_o.char_count     = '0;
    result_o.segment_bits   = '0;
    result_o.count_overflow = 1'b0;
    result_o.segment_end    = item_i.last_char;
    if (item_i.last_char) begin
      result_o.char_count     = chars_d;
      result_o.segment_bits   = total_sum[BitsW] ? BitsSat : total_sum[BitsW-1:0];
      result_o.count_overflow = ((BitsW+1)'(chars_d) >= cc_limit);
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NUMERIC;
      version_q <= 6'd1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_ENCODING_MODE) begin
        mode_q <= cfg_wdata_i[1:0];
      end else begin
        version_q <= cfg_wdata_i;
      end
    end
  end

  // segment state, cleared after the last character; a mode write drops the partial group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      fill_q    <= '0;
      chars_q   <= '0;
      dbits_q   <= '0;
      illegal_q <= 1'b0;
    end else if (cfg_we_i && (cfg_idx_i == REG_ENCODING_MODE)) begin
      acc_q  <= '0;
      fill_q <= '0;
    end else if (advance_i) begin
      if (item_i.last_char) begin
        acc_q     <= '0;
        fill_q    <= '0;
        chars_q   <= '0;
        dbits_q   <= '0;
        illegal_q <= 1'b0;
      end else begin
        acc_q     <= acc_d;
        fill_q    <= fill_d;
        chars_q   <= chars_d;
        dbits_q   <= dbits_d;
        illegal_q <= illegal_d;
      end
    end
  end

  // checks
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.last_char && !cfg_we_i |=>
      chars_q == '0 && fill_q == 2'd0 && !illegal_q && dbits_q == '0)
    else $error("segment state not cleared after last character");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3)
    else $error("group fill out of range");

  a_group_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i |-> (result_o.group_bits == 4'd0 || result_o.group_bits == 4'd4 ||
                   result_o.group_bits == 4'd6 || result_o.group_bits == 4'd7 ||
                   result_o.group_bits == 4'd8 || result_o.group_bits == 4'd10 ||
                   result_o.group_bits == 4'd11))
    else $error("illegal group width");

  a_numeric_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_NUMERIC |-> acc_q < 10'd100)
    else $error("numeric accumulator exceeds two digits");

endmodule

FILE: sv/qrse_out_stage.sv
// ----------------------------------------------------------------------------
// qrse_out_stage
// Result register; packs the result fields into the output beat.
// ----------------------------------------------------------------------------
module qrse_out_stage
  import qrse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  result_t             result_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [OutDataW-1:0] out_data_o,
  output logic                out_last_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // held until taken, reloaded when a new beat is computed
  always_comb begin
    valid_d = valid_q;
    if (advance_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      res_q <= result_i;
    end
  end

  // pack from the lowest bit up
  assign out_valid_o = valid_q;
  assign out_last_o  = res_q.segment_end;
  assign out_data_o  = {res_q.count_overflow, res_q.segment_bits, res_q.char_count,
                        res_q.bad_char, res_q.group_bits, res_q.group_value,
                        res_q.group_valid};

endmodule

FILE: tb/qrse_segment_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrse_segment_checker
// Scoreboard for the QR data segment encoder. It follows register writes and
// accepted character beats and keeps its own copy of the segment state. From
// these it predicts every result beat and compares the predicted fields
// against the result stream, oldest prediction first.
// ----------------------------------------------------------------------------
module qrse_segment_checker
  import qrse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // character stream
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] char_code
  input  logic                s_axis_tlast,   // last_char
  // result stream
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] group_valid, [11:1] group_value, [15:12] group_bits, [16] bad_char,
  // [29:17] char_count, [46:30] segment_bits, [47] count_overflow
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                m_axis_tlast,   // segment_end
  // configuration writes
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [5:0]          cfg_wdata_i,
  // status for the test sequence
  output int unsigned         pending_o,
  output int unsigned         errors_o
);

  // register copies
  logic [1:0]  mode_reg;
  logic [5:0]  version_reg;

  // segment state
  logic [9:0]  group_acc;
  logic [1:0]  group_chars;
  logic [12:0] seg_chars;
  logic [16:0] seg_data_bits;
  logic        seg_bad;

  result_t     results_due_q[$];
  int unsigned mismatches;

  // position in the 45-symbol set, ok cleared for anything outside it
  function automatic logic [5:0] alnum_code(input logic [7:0] c, output logic ok);
    ok = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) return 6'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h5A) return 6'(c - 8'h41 + 8'd10);
    case (c)
      8'h20: return 6'd36;
      8'h24: return 6'd37;
      8'h25: return 6'd38;
      8'h2A: return 6'd39;
      8'h2B: return 6'd40;
      8'h2D: return 6'd41;
      8'h2E: return 6'd42;
      8'h2F: return 6'd43;
      8'h3A: return 6'd44;
      default: ok = 1'b0;
    endcase
    return 6'd0;
  endfunction

  // character count indicator width per mode and version band
  function automatic logic [4:0] count_field_width(input mode_e m, input logic [5:0] ver);
    if (ver <= 6'd9) begin
      return (m == MODE_NUMERIC) ? 5'd10 : ((m == MODE_ALNUM) ? 5'd9 : 5'd8);
    end
    if (ver <= 6'd26) begin
      return (m == MODE_NUMERIC) ? 5'd12 : ((m == MODE_ALNUM) ? 5'd11 : 5'd16);
    end
    return (m == MODE_NUMERIC) ? 5'd14 : ((m == MODE_ALNUM) ? 5'd13 : 5'd16);
  endfunction

  function automatic void clear_segment();
    group_acc     = '0;
    group_chars   = '0;
    seg_chars     = '0;
    seg_data_bits = '0;
    seg_bad       = 1'b0;
  endfunction

  // advance the segment state by one character and form its result beat
  function automatic result_t encode_char(input logic [7:0] c, input logic last);
    result_t     r;
    mode_e       m;
    logic [5:0]  sym;
    logic        legal;
    logic [31:0] sum;
    logic [31:0] total;
    logic [3:0]  gbits;
    logic [10:0] gval;
    logic [4:0]  width;
    m     = MODE_BYTE;
    sym   = '0;
    legal = 1'b1;
    gbits = '0;
    gval  = '0;
    if (mode_reg == MODE_NUMERIC) m = MODE_NUMERIC;
    if (mode_reg == MODE_ALNUM) m = MODE_ALNUM;

    // symbol value, illegal characters pack as zero
    if (m == MODE_NUMERIC) begin
      legal = (c >= 8'h30 && c <= 8'h39);
      if (legal) sym = 6'(c - 8'h30);
    end else if (m == MODE_ALNUM) begin
      sym = alnum_code(c, legal);
    end
    if (!legal) seg_bad = 1'b1;
    if (seg_chars < MaxChars) seg_chars = seg_chars + 13'd1;

    // group packing
    case (m)
      MODE_NUMERIC: begin
        sum = 32'(group_acc) * 32'd10 + 32'(sym);
        group_chars = group_chars + 2'd1;
        if (group_chars == 2'd3 || last) begin
          gval  = 11'(sum & 32'h3FF);
          gbits = (group_chars == 2'd3) ? 4'd10 : 4'(group_chars) * 4'd3 + 4'd1;
          group_acc   = '0;
          group_chars = '0;
        end else begin
          group_acc = sum[9:0];
        end
      end
      MODE_ALNUM: begin
        sum = 32'(group_acc) * 32'd45 + 32'(sym);
        group_chars = group_chars + 2'd1;
        if (group_chars >= 2'd2 || last) begin
          gval  = sum[10:0];
          gbits = (group_chars >= 2'd2) ? 4'd11 : 4'd6;
          group_acc   = '0;
          group_chars = '0;
        end else begin
          group_acc = sum[9:0];
        end
      end
      default: begin
        gval  = {3'b000, c};
        gbits = 4'd8;
      end
    endcase

    total = 32'(seg_data_bits) + 32'(gbits);
    seg_data_bits = (total > 32'(BitsSat)) ? BitsSat : total[16:0];

    r.group_valid    = (gbits != 4'd0);
    r.group_value    = gval;
    r.group_bits     = gbits;
    r.bad_char       = seg_bad;
    r.char_count     = '0;
    r.segment_bits   = '0;
    r.count_overflow = 1'b0;
    r.segment_end    = last;

    // segment summary, then a fresh segment
    if (last) begin
      width = count_field_width(m, version_reg);
      total = 32'd4 + 32'(width) + 32'(seg_data_bits);
      r.char_count     = seg_chars;
      r.segment_bits   = (total > 32'(BitsSat)) ? BitsSat : total[16:0];
      r.count_overflow = (32'(seg_chars) >= (32'd1 << width));
      clear_segment();
    end
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  // register writes, predictions on input beats, checks on result beats
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    result_t want;
    if (!rst_ni) begin
      mode_reg    = MODE_NUMERIC;
      version_reg = 6'd1;
      clear_segment();
      results_due_q.delete();
      mismatches = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_ENCODING_MODE) begin
          mode_reg    = cfg_wdata_i[1:0];
          group_acc   = '0;
          group_chars = '0;
        end else if (cfg_idx_i == REG_SYMBOL_VERSION) begin
          version_reg = cfg_wdata_i;
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        want = encode_char(s_axis_tdata[7:0], s_axis_tlast);
        results_due_q.insert(results_due_q.size(), want);
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due_q.size() == 0) begin
          $error("result beat with no character outstanding");
          mismatches++;
        end else begin
          want = results_due_q.pop_front();
          compare_field("group_valid", 32'(want.group_valid), 32'(m_axis_tdata[0]));
          compare_field("group_value", 32'(want.group_value), 32'(m_axis_tdata[11:1]));
          compare_field("group_bits", 32'(want.group_bits), 32'(m_axis_tdata[15:12]));
          compare_field("bad_char", 32'(want.bad_char), 32'(m_axis_tdata[16]));
          compare_field("char_count", 32'(want.char_count), 32'(m_axis_tdata[29:17]));
          compare_field("segment_bits", 32'(want.segment_bits),
                        32'(m_axis_tdata[46:30]));
          compare_field("count_overflow", 32'(want.count_overflow),
                        32'(m_axis_tdata[47]));
          compare_field("segment_end", 32'(want.segment_end), 32'(m_axis_tlast));
        end
      end

      pending_o <= results_due_q.size();
      errors_o  <= mismatches;
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the QR data segment encoder. A short directed run hits the
// group widths, table extremes, illegal characters and odd register values,
// then random segments run under changing modes and versions with random
// gaps on both streams, and a long byte segment pushes the count past the
// indicator width. The checker does all comparisons.
// ----------------------------------------------------------------------------
module tb_top;
  import qrse_pkg::*;

  localparam int unsigned TimeoutCycles = 50000;
  localparam int unsigned RandPhases    = 8;
  localparam int unsigned PhaseChars    = 60;
  localparam int unsigned LongChars     = 280;
  localparam int unsigned HoldAtBeat    = 200;
  localparam int unsigned HoldCycles    = 60;
  localparam int unsigned TailCycles    = 4;
  // mode value 3 is not a named mode, the block runs it as byte mode
  localparam logic [1:0]  ModeAlias     = 2'd3;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // [7:0] char_code
  logic                s_axis_tlast  = 1'b0; // last_char
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [0] group_valid, [11:1] group_value, [15:12] group_bits, [16] bad_char,
  // [29:17] char_count, [46:30] segment_bits, [47] count_overflow
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;         // segment_end
  logic                cfg_we        = 1'b0;
  logic                cfg_idx       = 1'b0;
  logic [5:0]          cfg_wdata     = '0;

  int unsigned results_pending;
  int unsigned check_errors;

  bit          idle_on       = 1'b1;
  logic [1:0]  cur_mode      = MODE_NUMERIC;
  int unsigned chars_sent    = 0;
  int unsigned segments_sent = 0;
  int unsigned settings_cnt  = 0;
  int unsigned cycle_cnt     = 0;

  qr_data_segment_encoder u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  qrse_segment_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .pending_o     (results_pending),
    .errors_o      (check_errors)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_cnt < TimeoutCycles) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("DONE: errors detected");
    $finish;
  end

  // a character that the current mode accepts
  function automatic logic [7:0] legal_char();
    int unsigned sym;
    if (cur_mode == MODE_NUMERIC) return 8'h30 + 8'($urandom_range(0, 9));
    if (cur_mode == MODE_ALNUM) begin
      sym = $urandom_range(0, 44);
      if (sym < 10) return 8'h30 + 8'(sym);
      if (sym < 36) return 8'h41 + 8'(sym - 10);
      case (sym)
        36: return 8'h20;
        37: return 8'h24;
        38: return 8'h25;
        39: return 8'h2A;
        40: return 8'h2B;
        41: return 8'h2D;
        42: return 8'h2E;
        43: return 8'h2F;
        default: return 8'h3A;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // one character beat, with an optional gap in front
  task automatic send_char(input logic [7:0] code, input logic last);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    chars_sent++;
    if (last) segments_sent++;
  endtask

  // segment of legal characters, noisy ones get a random byte now and then
  task automatic send_segment(input int unsigned len, input bit closed, input bit noisy);
    logic [7:0] code;
    for (int unsigned i = 0; i < len; i++) begin
      code = (noisy && $urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : legal_char();
      send_char(code, closed && (i == len - 1));
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // write both registers once the block is idle
  task automatic apply_settings(input logic [1:0] mode, input logic [5:0] version);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_ENCODING_MODE;
    cfg_wdata <= {4'b0000, mode};
    @(posedge clk);
    cfg_idx   <= REG_SYMBOL_VERSION;
    cfg_wdata <= version;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mode = mode;
    settings_cnt++;
  endtask

  function automatic logic [5:0] phase_version(input int unsigned p);
    case (p)
      0: return 6'd1;
      1: return 6'd40;
      2: return 6'd9;
      3: return 6'd26;
      4: return 6'd27;
      5: return 6'd10;
      6: return 6'd41;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  // result side: random gaps, one long hold-off to back up the input
  initial begin : result_sink
    int unsigned gap;
    int unsigned beats;
    beats = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (beats == HoldAtBeat) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      beats++;
    end
  end

  // main sequence
  initial begin
    int unsigned phase_chars;
    int unsigned len;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // numeric at reset values: full group, two-digit and one-digit tails
    repeat (4) send_char(8'h39, 1'b0);
    send_char(8'h39, 1'b1);
    send_char(8'h30, 1'b1);
    // illegal null character, flag stays up to the segment end
    send_char(8'h00, 1'b0);
    send_char(8'h35, 1'b1);
    // partial group left open, dropped by the next mode write
    send_char(8'h31, 1'b0);
    send_char(8'h32, 1'b0);

    // alphanumeric: table ends, pair and single leftover
    apply_settings(MODE_ALNUM, 6'd10);
    send_char(8'h5A, 1'b0);
    send_char(8'h3A, 1'b0);
    send_char(8'h20, 1'b1);
    send_char(8'h61, 1'b0);
    send_char(8'h5B, 1'b1);

    // byte mode extremes and the odd register values
    apply_settings(MODE_BYTE, 6'd40);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    apply_settings(ModeAlias, 6'd0);
    send_char(8'hA5, 1'b1);
    apply_settings(ModeAlias, 6'd63);
    send_char(8'h5A, 1'b1);

    // random segments over a spread of settings
    for (int unsigned p = 0; p < RandPhases; p++) begin
      apply_settings(2'(p % 4), phase_version(p));
      idle_on = (p % 4 != 3);
      phase_chars = 0;
      while (phase_chars < PhaseChars) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_segment(len, 1'b1, 1'b1);
        phase_chars += len;
      end
      if ($urandom_range(0, 1) == 1) send_segment($urandom_range(1, 2), 1'b0, 1'b1);
    end

    // long byte segment: count past the 8-bit indicator width
    idle_on = 1'b0;
    apply_settings(MODE_BYTE, 6'd9);
    send_segment(LongChars, 1'b1, 1'b0);

    drain();
    repeat (TailCycles) @(posedge clk);

    $display("covered %0d characters in %0d closed segments over %0d register settings",
             chars_sent, segments_sent, settings_cnt);
    $display("all modes and version bands, illegal input, dropped groups, count overflow");
    if (check_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
